>>> sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg: shared types and defaults for the dda line rasterizer
// Holds the default geometry and the status struct of the shared divider.
// ----------------------------------------------------------------------------
package dda_pkg;

   // default coordinate and fraction widths
   localparam int COORD_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF  = 16;

   // status from the serial divider to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> sv/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer: pull-mode dda line rasterizer
// Load beats set up a line and return its start pixel; step beats return
// the following pixels, rounded half away from zero, the last one on tlast.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) goes through ST_LEN, which computes the length, and
// ST_START, which sets up the accumulators; then both step increments come
// from one shared restoring divider that produces one quotient bit per cycle
// (FRAC_BITS+1 bits plus a done pulse), first for x and then for y, and
// ST_ROUND rounds the start pixel into the response register, waiting while
// that register holds a pixel not yet taken; a zero-length line skips the
// divider. A step beat (tuser 1) does one accumulator add when it is accepted,
// then ST_ROUND as above. req_tready is high only while no beat is in
// work; the response register lets a new beat in while the previous pixel
// still waits. A step beat with no active line returns a beat with tuser 0
// and zero data.
module dda_line_rasterizer
   import dda_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // request: tdata = x_start, y_start, x_end, y_end (lowest first), zero pad
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // request: tuser = req_type
   input  logic                                  req_tuser,
   // response: tdata = pixel_x, pixel_y (lowest first), zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   // response: tuser = pixel_valid
   output logic                                  rsp_tuser,
   // response: tlast = last_pixel
   output logic                                  rsp_tlast
);

   localparam int LEN_W   = COORD_BITS + 1;
   localparam int STEP_W  = FRAC_BITS + 2;
   localparam int ACC_W   = COORD_BITS + FRAC_BITS + 1;
   localparam int RDATA_W = ((2*COORD_BITS+7)/8)*8;
   localparam logic [ACC_W:0] HALF_Q = (ACC_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [STEP_W-1:0] ONE_Q = STEP_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_START,
      ST_DIV_X,
      ST_DIV_Y,
      ST_ROUND
   } state_type;

   state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [COORD_BITS:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [LEN_W-1:0]             ax_ff, ax_in, ay_ff, ay_in, len_ff, len_in;
   logic signed [ACC_W-1:0]      x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic signed [STEP_W-1:0]     x_step_ff, x_step_in, y_step_ff, y_step_in;
   logic [LEN_W-1:0]             left_ff, left_in;
   logic                         pvalid_ff, pvalid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_user_ff, rsp_user_in;

   // request fields
   logic [COORD_BITS-1:0] req_x_start, req_y_start, req_x_end, req_y_end;
   logic                  req_accept;

   // divider hookup
   logic                  div_start;
   logic [LEN_W-1:0]      div_num;
   div_sts_type           div_sts;
   logic [FRAC_BITS:0]    div_quot;

   assign req_x_start = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign req_y_start = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign req_x_end   = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign req_y_end   = req_tdata[3*COORD_BITS +: COORD_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // divider runs x first, then y
   assign div_num   = (state_ff == ST_START) ? ax_ff : ay_ff;
   assign div_start = ((state_ff == ST_START) && (len_ff != '0)) ||
                      ((state_ff == ST_DIV_X) && div_sts.done);

   dda_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   // rounding helpers and next state
   logic [ACC_W-1:0]      x_mag, y_mag;
   logic [ACC_W:0]        x_sum, y_sum;
   logic [COORD_BITS-1:0] x_rnd, y_rnd;
   logic signed [STEP_W-1:0] quot_ext;
   logic                  rsp_free;

   always_comb begin
      // round half away from zero on the accumulators
      x_mag = x_acc_ff[ACC_W-1] ? ACC_W'(-x_acc_ff) : ACC_W'(x_acc_ff);
      y_mag = y_acc_ff[ACC_W-1] ? ACC_W'(-y_acc_ff) : ACC_W'(y_acc_ff);
      x_sum = {1'b0, x_mag} + HALF_Q;
      y_sum = {1'b0, y_mag} + HALF_Q;
      x_rnd = x_acc_ff[ACC_W-1] ? -x_sum[FRAC_BITS +: COORD_BITS]
                                :  x_sum[FRAC_BITS +: COORD_BITS];
      y_rnd = y_acc_ff[ACC_W-1] ? -y_sum[FRAC_BITS +: COORD_BITS]
                                :  y_sum[FRAC_BITS +: COORD_BITS];
      quot_ext = {1'b0, div_quot};
      rsp_free = !rsp_valid_ff || rsp_tready;

      state_in     = state_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      len_in       = len_ff;
      x_acc_in     = x_acc_ff;
      y_acc_in     = y_acc_ff;
      x_step_in    = x_step_ff;
      y_step_in    = y_step_ff;
      left_in      = left_ff;
      pvalid_in    = pvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_tuser) begin
                  x1_in    = req_x_start;
                  y1_in    = req_y_start;
                  dx_in    = {req_x_end[COORD_BITS-1], req_x_end} -
                             {req_x_start[COORD_BITS-1], req_x_start};
                  dy_in    = {req_y_end[COORD_BITS-1], req_y_end} -
                             {req_y_start[COORD_BITS-1], req_y_start};
                  state_in = ST_LEN;
               end else begin
                  // step beat: advance only while a line is active
                  if (left_ff != '0) begin
                     x_acc_in  = x_acc_ff +
                                 {{(ACC_W-STEP_W){x_step_ff[STEP_W-1]}}, x_step_ff};
                     y_acc_in  = y_acc_ff +
                                 {{(ACC_W-STEP_W){y_step_ff[STEP_W-1]}}, y_step_ff};
                     left_in   = left_ff - 1'b1;
                     pvalid_in = 1'b1;
                  end else begin
                     pvalid_in = 1'b0;
                  end
                  state_in = ST_ROUND;
               end
            end
         end
         ST_LEN: begin
            ax_in    = dx_ff[COORD_BITS] ? LEN_W'(-dx_ff) : LEN_W'(dx_ff);
            ay_in    = dy_ff[COORD_BITS] ? LEN_W'(-dy_ff) : LEN_W'(dy_ff);
            len_in   = (ax_in > ay_in) ? ax_in : ay_in;
            state_in = ST_START;
         end
         ST_START: begin
            x_acc_in  = {x1_ff[COORD_BITS-1], x1_ff, {FRAC_BITS{1'b0}}};
            y_acc_in  = {y1_ff[COORD_BITS-1], y1_ff, {FRAC_BITS{1'b0}}};
            left_in   = len_ff;
            pvalid_in = 1'b1;
            if (len_ff == '0) begin
               x_step_in = '0;
               y_step_in = '0;
               state_in  = ST_ROUND;
            end else begin
               state_in  = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_sts.done) begin
               x_step_in = dx_ff[COORD_BITS] ? -quot_ext : quot_ext;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_sts.done) begin
               y_step_in = dy_ff[COORD_BITS] ? -quot_ext : quot_ext;
               state_in  = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = pvalid_ff;
               rsp_x_in     = pvalid_ff ? x_rnd : '0;
               rsp_y_in     = pvalid_ff ? y_rnd : '0;
               rsp_last_in  = pvalid_ff && (left_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         x_step_ff    <= '0;
         y_step_ff    <= '0;
         left_ff      <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         x_step_ff    <= x_step_in;
         y_step_ff    <= y_step_in;
         left_ff      <= left_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      len_ff      <= len_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RDATA_W'({rsp_y_ff, rsp_x_ff});

   // the last pixel is always a real pixel
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_user_ff)
      else $error("last flag on an empty beat");

   // an empty beat carries zero data
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_user_ff |-> (rsp_tdata == '0))
      else $error("empty beat with data");

   // step increments stay within one pixel
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (x_step_ff <= ONE_Q) && (x_step_ff >= -ONE_Q) &&
      (y_step_ff <= ONE_Q) && (y_step_ff >= -ONE_Q))
      else $error("step increment out of range");

endmodule

>>> sv/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div: serial restoring divider for the line step
// Computes (num << FRAC_BITS) / den for num <= den, den != 0, one quotient
// bit per cycle, FRAC_BITS+1 bits; done pulses for one cycle with the last bit.
// ----------------------------------------------------------------------------
module dda_div
   import dda_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS:0]   num,
   input  logic [COORD_BITS:0]   den,
   output div_sts_type           sts,
   output logic [FRAC_BITS:0]    quot
);

   localparam int LEN_W = COORD_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAC_BITS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W:0]    rem_ff, rem_in;
   logic [LEN_W-1:0]  den_ff, den_in;
   logic [FRAC_BITS:0] quot_ff, quot_in;

   logic [LEN_W:0]    shifted;
   logic [LEN_W+1:0]  diff;
   logic              ge;

   // shared compare and subtract: first bit uses the remainder unshifted
   always_comb begin
      shifted = (cnt_ff == '0) ? rem_ff : {rem_ff[LEN_W-1:0], 1'b0};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ge      = ~diff[LEN_W+1];
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[LEN_W:0] : shifted;
         quot_in = {quot_ff[FRAC_BITS-1:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = quot_ff;

   // start only when the unit is free
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");

   // done follows the last busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");

   // step magnitude never exceeds one
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (quot_ff[FRAC_BITS] == 1'b0 || quot_ff[FRAC_BITS-1:0] == '0))
      else $error("divider quotient above one");

endmodule
